// File: sv/pcra_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and mask helpers of the paged run allocator
package pcra_pkg;

	// store geometry
	localparam int PAGE_COUNT       = 128;
	localparam int ENTRIES_PER_PAGE = 64;
	localparam int HEADER_RESERVED  = 13;

	// header reserve limited to one full page
	localparam int HDR_EFF = (HEADER_RESERVED > ENTRIES_PER_PAGE) ?
		ENTRIES_PER_PAGE : HEADER_RESERVED;

	// field and index widths
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int OFF_W  = $clog2(ENTRIES_PER_PAGE);
	localparam int LEN_W  = 7;
	localparam int CNT_W  = 7;
	localparam int IDX_W  = 13;

	// command and status codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_FREE    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef logic [ENTRIES_PER_PAGE-1:0] bitmap_t;

	// one page store entry
	typedef struct packed {
		bitmap_t          bitmap;
		logic [CNT_W-1:0] count;
	} page_entry_t;

	// write request into the page store
	typedef struct packed {
		logic              en;
		logic [PAGE_W-1:0] addr;
		page_entry_t       data;
	} page_wr_t;

	// low n bits set, limited to a page
	function automatic bitmap_t run_mask(input logic [LEN_W-1:0] n);
		bitmap_t m;
		m = '0;
		for (int i = 0; i < ENTRIES_PER_PAGE; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

	// bits off .. off+n-1 set, those past the page end dropped
	function automatic bitmap_t clear_mask(input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] n);
		bitmap_t m;
		m = '0;
		for (int i = 0; i < ENTRIES_PER_PAGE; i++) begin
			m[i] = (i >= int'(off)) && (i < int'(off) + int'(n));
		end
		return m;
	endfunction

	// contents of a page after reset
	function automatic page_entry_t page_reset(input logic [PAGE_W-1:0] page);
		page_entry_t e;
		if (page == '0) begin
			e.bitmap = run_mask(LEN_W'(HDR_EFF));
			e.count  = CNT_W'(ENTRIES_PER_PAGE - HDR_EFF);
		end else begin
			e.bitmap = '0;
			e.count  = CNT_W'(ENTRIES_PER_PAGE);
		end
		return e;
	endfunction

endpackage

// File: sv/pcra_ifs.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the paged run allocator
interface pcra_req_if;
	import pcra_pkg::*;

	logic             valid;
	logic             ready;
	logic             cmd;
	logic [LEN_W-1:0] run_length;
	logic [IDX_W-1:0] first_entry;

	modport source (output valid, cmd, run_length, first_entry, input ready);
	modport sink   (input valid, cmd, run_length, first_entry, output ready);
endinterface

interface pcra_rsp_if;
	import pcra_pkg::*;

	logic             valid;
	logic             ready;
	logic             status;
	logic [IDX_W-1:0] entry_index;

	modport source (output valid, status, entry_index, input ready);
	modport sink   (input valid, status, entry_index, output ready);
endinterface

// File: sv/pcra_store.sv
`timescale 1ns / 1ps
// page store: bitmap and free count per page, one read and one write port
module pcra_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [pcra_pkg::PAGE_W-1:0] rd_addr,
	output pcra_pkg::page_entry_t      rd_data,
	input  pcra_pkg::page_wr_t         wr
);
	import pcra_pkg::*;

	page_entry_t             mem [PAGE_COUNT];
	page_entry_t             rd_data_q;
	logic [PAGE_W-1:0]       rd_page_q;
	logic [PAGE_COUNT-1:0]   written_q;
	logic                    rd_written_q;

	// storage array, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_page_q <= rd_addr;
		end
	end

	// per page written flags, a page never written reads as its reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : page_reset(rd_page_q);

endmodule

// File: sv/pcra_fit.sv
`timescale 1ns / 1ps
// lowest run of clear bits of a given length within one page bitmap
module pcra_fit (
	input  pcra_pkg::bitmap_t          bitmap,
	input  pcra_pkg::bitmap_t          run,
	input  logic [pcra_pkg::LEN_W-1:0] n,
	output logic                       found,
	output logic [pcra_pkg::OFF_W-1:0] off
);
	import pcra_pkg::*;

	logic [ENTRIES_PER_PAGE-1:0] fits;

	// one candidate start per offset
	for (genvar j = 0; j < ENTRIES_PER_PAGE; j++) begin : g_cand
		assign fits[j] = ((j + int'(n)) <= ENTRIES_PER_PAGE) &&
			(((bitmap >> j) & run) == '0);
	end

	// lowest fitting offset wins
	always_comb begin
		found = |fits;
		off   = '0;
		for (int j = ENTRIES_PER_PAGE - 1; j >= 0; j--) begin
			if (fits[j]) begin
				off = OFF_W'(j);
			end
		end
	end

endmodule

// File: sv/paged_contiguous_run_allocator.sv
`timescale 1ns / 1ps
// top level: command sequencer, page scan and update around the page store
//
//  channel | dir | word fields                        | handshake
//  req     | in  | cmd, run_length, first_entry       | valid / ready
//  rsp     | out | status, entry_index                | valid / ready
//
// allocate: one page read per cycle from the page store; the scan stops at the first
//   page that takes the run, or after the last page, which reports full
// free: one read and one write of the addressed page
// reset: page store flagged unwritten, pages read as formatted contents at once
// one word in flight; a new word is taken while the last result waits on rsp
module paged_contiguous_run_allocator (
	input logic        clk,
	input logic        arst_n,
	pcra_req_if.sink   req,
	pcra_rsp_if.source rsp
);
	import pcra_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FREE, ST_DONE} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  n_q;
	bitmap_t           run_q;
	logic [PAGE_W-1:0] issue_q;
	logic [PAGE_W-1:0] eval_page_s1;
	logic [PAGE_W-1:0] free_page_q;
	logic [OFF_W-1:0]  free_off_q;
	logic              free_ok_q;
	logic              res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [IDX_W-1:0]  out_index_q;

	logic              req_acc;
	logic              rd_en;
	logic [PAGE_W-1:0] rd_addr;
	page_entry_t       rd_ent;
	page_wr_t          wr;
	logic [IDX_W-1:0]  req_page_full;
	logic [OFF_W-1:0]  req_off;
	logic              skip;
	logic              bring;
	logic              too_long;
	bitmap_t           bm_in;
	logic [CNT_W-1:0]  cnt_in;
	logic              fit_found;
	logic [OFF_W-1:0]  fit_off;
	logic              hit;
	logic              last_page;
	logic [IDX_W-1:0]  hit_index;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// page and offset of the word's first entry
	assign req_page_full = IDX_W'(req.first_entry / ENTRIES_PER_PAGE);
	assign req_off       = OFF_W'(req.first_entry % ENTRIES_PER_PAGE);

	// read port: addressed page (free) or page 0 (allocate) on accept, next page each scan cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = issue_q;
		if (state_q == ST_IDLE) begin
			rd_en   = req_acc;
			rd_addr = (req.cmd == CMD_FREE) ? PAGE_W'(req_page_full) : '0;
		end else if (state_q == ST_SCAN) begin
			rd_en = 1'b1;
		end
	end

	pcra_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_ent),
		.wr      (wr)
	);

	// page under evaluation, brought in first if unused
	always_comb begin
		skip     = rd_ent.count < n_q;
		bring    = rd_ent.count == CNT_W'(ENTRIES_PER_PAGE);
		too_long = n_q > LEN_W'(ENTRIES_PER_PAGE);
		bm_in    = bring ? bitmap_t'(1) : rd_ent.bitmap;
		cnt_in   = bring ? CNT_W'(ENTRIES_PER_PAGE - 1) : rd_ent.count;
	end

	pcra_fit u_fit (
		.bitmap (bm_in),
		.run    (run_q),
		.n      (n_q),
		.found  (fit_found),
		.off    (fit_off)
	);

	assign hit       = !skip && !too_long && fit_found;
	assign last_page = (eval_page_s1 == PAGE_W'(PAGE_COUNT - 1));
	assign hit_index = IDX_W'(int'(eval_page_s1) * ENTRIES_PER_PAGE + int'(fit_off));

	// write back: scanned page that was brought in or taken, or freed page
	always_comb begin
		wr = '0;
		case (state_q)
			ST_SCAN: begin
				wr.en   = !skip && (bring || hit);
				wr.addr = eval_page_s1;
				if (hit) begin
					wr.data.bitmap = bm_in | (run_q << fit_off);
					wr.data.count  = cnt_in - n_q;
				end else begin
					wr.data.bitmap = bm_in;
					wr.data.count  = cnt_in;
				end
			end
			ST_FREE: begin
				wr.en          = free_ok_q;
				wr.addr        = free_page_q;
				wr.data.bitmap = rd_ent.bitmap & ~clear_mask(free_off_q, n_q);
				wr.data.count  = rd_ent.count + n_q;
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			n_q          <= '0;
			run_q        <= '0;
			issue_q      <= '0;
			eval_page_s1 <= '0;
			free_page_q  <= '0;
			free_off_q   <= '0;
			free_ok_q    <= 1'b0;
			res_status_q <= STATUS_OK;
			res_index_q  <= '0;
			out_status_q <= STATUS_OK;
			out_index_q  <= '0;
		end else begin
			// response valid: load from done, drop on handshake
			if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				eval_page_s1 <= rd_addr;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						n_q         <= req.run_length;
						run_q       <= run_mask(req.run_length);
						issue_q     <= PAGE_W'(1);
						free_page_q <= PAGE_W'(req_page_full);
						free_off_q  <= req_off;
						free_ok_q   <= (int'(req_page_full) < PAGE_COUNT);
						state_q     <= (req.cmd == CMD_FREE) ? ST_FREE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					issue_q <= issue_q + PAGE_W'(1);
					if (hit) begin
						res_status_q <= STATUS_OK;
						res_index_q  <= hit_index;
						state_q      <= ST_DONE;
					end else if (last_page) begin
						res_status_q <= STATUS_FULL;
						res_index_q  <= '0;
						state_q      <= ST_DONE;
					end
				end
				ST_FREE: begin
					res_status_q <= STATUS_OK;
					res_index_q  <= '0;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_index = out_index_q;

	// store writes only while a page is being evaluated or freed
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_SCAN || state_q == ST_FREE))
		else $error("page store written outside scan or free");

	// scan read pipeline stays one page ahead of evaluation
	a_scan_align: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (PAGE_W'(eval_page_s1 + PAGE_W'(1)) == issue_q))
		else $error("scan read and evaluation out of step");

	// a new result is only loaded from the done state
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("response loaded outside done state");

	// a full report carries index zero
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_FULL) |-> (out_index_q == '0))
		else $error("full response with nonzero index");

endmodule

// File: tb/paged_contiguous_run_allocator_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the paged run allocator: shadow page store, random traffic, stalls
module paged_contiguous_run_allocator_test;
	import pcra_pkg::*;

	localparam int RANDOM_WORDS   = 1250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 20;

	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] run_length;
		logic [IDX_W-1:0] first_entry;
	} cmd_word_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] entry_index;
	} rsp_word_t;

	typedef struct {
		int first;
		int len;
	} run_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// driven copies of the block inputs, known from time zero
	logic             tx_valid = 1'b0;
	logic             tx_cmd   = CMD_ALLOC;
	logic [LEN_W-1:0] tx_len   = '0;
	logic [IDX_W-1:0] tx_first = '0;
	logic             rx_ready = 1'b0;

	pcra_req_if req_ch ();
	pcra_rsp_if rsp_ch ();

	assign req_ch.valid       = tx_valid;
	assign req_ch.cmd         = tx_cmd;
	assign req_ch.run_length  = tx_len;
	assign req_ch.first_entry = tx_first;
	assign rsp_ch.ready       = rx_ready;

	paged_contiguous_run_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow page store
	bitmap_t          shadow_map  [PAGE_COUNT];
	logic [CNT_W-1:0] shadow_free [PAGE_COUNT];

	cmd_word_t pending_cmds [$];
	rsp_word_t due_results  [$];
	run_t      live_runs    [$];

	int  mismatch_count = 0;
	int  gap_left       = 0;
	int  stall_left     = 0;
	int  hold_asks      = 0;
	int  holds_done     = 0;
	int  quiet_cycles   = 0;
	bit  tx_steady      = 1'b0;
	bit  rx_steady      = 1'b0;
	logic req_fire      = 1'b0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// low n bits set, all of them from a full page on
	function automatic bitmap_t low_mask(input int n);
		if (n >= ENTRIES_PER_PAGE)
			return '1;
		return (bitmap_t'(1) << n) - bitmap_t'(1);
	endfunction

	// formatted empty directory
	function automatic void format_store();
		int hdr;
		hdr = (HEADER_RESERVED > ENTRIES_PER_PAGE) ? ENTRIES_PER_PAGE : HEADER_RESERVED;
		for (int p = 0; p < PAGE_COUNT; p++) begin
			shadow_map[p]  = '0;
			shadow_free[p] = CNT_W'(ENTRIES_PER_PAGE);
		end
		shadow_map[0]  = low_mask(hdr);
		shadow_free[0] = CNT_W'(ENTRIES_PER_PAGE - hdr);
	endfunction

	// first fit over pages in order, lowest clear run within the page
	function automatic void take_run(input int n, output logic status,
			output logic [IDX_W-1:0] where);
		bitmap_t run;
		bit      found;
		run    = low_mask(n);
		found  = 1'b0;
		status = STATUS_FULL;
		where  = '0;
		for (int p = 0; p < PAGE_COUNT && !found; p++) begin
			if (int'(shadow_free[p]) >= n) begin
				// page not in use yet: bring it in with its header entry
				if (int'(shadow_free[p]) == ENTRIES_PER_PAGE) begin
					shadow_map[p]  = bitmap_t'(1);
					shadow_free[p] = CNT_W'(ENTRIES_PER_PAGE - 1);
				end
				if (n <= ENTRIES_PER_PAGE) begin
					for (int j = 0; j + n <= ENTRIES_PER_PAGE && !found; j++) begin
						if (((shadow_map[p] >> j) & run) == '0) begin
							shadow_free[p] = shadow_free[p] - CNT_W'(n);
							shadow_map[p]  = shadow_map[p] | (run << j);
							where  = IDX_W'(p * ENTRIES_PER_PAGE + j);
							status = STATUS_OK;
							found  = 1'b1;
						end
					end
				end
			end
		end
	endfunction

	// unchecked release: count grows by the full length, bits past the page end dropped
	function automatic void give_back_run(input int first, input int n);
		int p;
		int off;
		p   = first / ENTRIES_PER_PAGE;
		off = first % ENTRIES_PER_PAGE;
		if (p < PAGE_COUNT) begin
			shadow_free[p] = shadow_free[p] + CNT_W'(n);
			for (int i = 0; i < n; i++) begin
				if (off + i < ENTRIES_PER_PAGE)
					shadow_map[p][off + i] = 1'b0;
			end
		end
	endfunction

	// sender gap after a word, mostly short
	function automatic int pause_len(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver stall after a ready cycle, mostly none
	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic int pick_run_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom_range(1, 8);
		if (r < 75)
			return $urandom_range(9, 24);
		if (r < 96)
			return $urandom_range(25, 63);
		return ENTRIES_PER_PAGE;
	endfunction

	task automatic queue_cmd(input logic c, input int n, input int first);
		cmd_word_t w;
		w.cmd         = c;
		w.run_length  = LEN_W'(n);
		w.first_entry = IDX_W'(first);
		pending_cmds.push_back(w);
	endtask

	// block until every queued word is taken and every result has come back
	task automatic wait_drained();
		while (!(pending_cmds.size() == 0 && !tx_valid && due_results.size() == 0))
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!tx_valid || req_fire)) begin
			if (gap_left > 0) begin
				tx_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				tx_valid <= 1'b1;
				tx_cmd   <= pending_cmds[0].cmd;
				tx_len   <= pending_cmds[0].run_length;
				tx_first <= pending_cmds[0].first_entry;
				gap_left <= pause_len(tx_steady);
				void'(pending_cmds.pop_front());
			end else begin
				tx_valid <= 1'b0;
			end
		end
	end

	// response ready with random stalls and requested long holds
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_done < hold_asks) begin
				rx_ready   <= 1'b0;
				stall_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end else if (stall_left > 0) begin
				rx_ready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				rx_ready   <= 1'b1;
				stall_left <= rx_steady ? 0 : stall_len();
			end
		end
	end

	// monitor: predict on each accepted request word, check each accepted response word
	always @(posedge clk) begin
		logic             st;
		logic [IDX_W-1:0] idx;
		rsp_word_t        want;
		run_t             taken;
		if (arst_n) begin
			if (tx_valid && req_ch.ready) begin
				if (tx_cmd == CMD_ALLOC) begin
					take_run(int'(tx_len), st, idx);
					if (st == STATUS_OK && tx_len != '0) begin
						taken.first = int'(idx);
						taken.len   = int'(tx_len);
						live_runs.push_back(taken);
					end
				end else begin
					give_back_run(int'(tx_first), int'(tx_len));
					st  = STATUS_OK;
					idx = '0;
				end
				want.status      = st;
				want.entry_index = idx;
				due_results.push_back(want);
			end
			if (rsp_ch.valid && rx_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected word, status %0b entry_index %0d", $time,
						rsp_ch.status, rsp_ch.entry_index);
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0b actual %0b", $time,
							want.status, rsp_ch.status);
						mismatch_count++;
					end
					if (rsp_ch.entry_index !== want.entry_index) begin
						$display("%0t: entry_index expected %0d actual %0d", $time,
							want.entry_index, rsp_ch.entry_index);
						mismatch_count++;
					end
				end
			end
			req_fire <= tx_valid && req_ch.ready;
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tx_valid && req_ch.ready) || (rsp_ch.valid && rx_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// reset, directed words, then random phases
	initial begin
		int   random_words;
		int   phase;
		int   phase_words;
		int   alloc_pct;
		bit   fill_phase;
		int   k;
		run_t victim;
		random_words = 0;
		format_store();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// header reserve: first single entry lands right after it
		queue_cmd(CMD_ALLOC, 1, 0);
		// zero length allocate returns offset 0 of the first page
		queue_cmd(CMD_ALLOC, 0, 0);
		// whole page minus header on a fresh page
		queue_cmd(CMD_ALLOC, ENTRIES_PER_PAGE - 1, 0);
		// full page run: every unused page gets brought in, then store full
		queue_cmd(CMD_ALLOC, ENTRIES_PER_PAGE, 0);
		// runs longer than a page
		queue_cmd(CMD_ALLOC, ENTRIES_PER_PAGE + 1, 0);
		queue_cmd(CMD_ALLOC, 127, 0);
		queue_cmd(CMD_FREE, ENTRIES_PER_PAGE - 1, ENTRIES_PER_PAGE + 1);
		// free running past the page end, count grows past a full page
		queue_cmd(CMD_FREE, 10, (PAGE_COUNT - 1) * ENTRIES_PER_PAGE + 60);
		// page with an oversized count is skipped for a long run
		queue_cmd(CMD_ALLOC, 70, 0);
		// top entry with the longest length, count wraps
		queue_cmd(CMD_FREE, 127, 8191);
		// release the header so page 0 drops out of use, then reuse it
		queue_cmd(CMD_FREE, HEADER_RESERVED, 0);
		queue_cmd(CMD_FREE, 1, HEADER_RESERVED);
		queue_cmd(CMD_ALLOC, 5, 0);
		queue_cmd(CMD_ALLOC, 0, 0);
		queue_cmd(CMD_FREE, 0, 0);
		// free of an area never allocated
		queue_cmd(CMD_FREE, ENTRIES_PER_PAGE, 4000);
		queue_cmd(CMD_ALLOC, 100, 0);
		queue_cmd(CMD_ALLOC, 2, 0);
		queue_cmd(CMD_ALLOC, ENTRIES_PER_PAGE - 1, 0);
		queue_cmd(CMD_FREE, 1, ENTRIES_PER_PAGE);
		wait_drained();

		// random phases; sender pauses at each phase end until all results are back
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			fill_phase = (phase % 5 == 2);
			tx_steady  = ($urandom_range(0, 3) == 0);
			rx_steady  = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: alloc_pct = 90;
				1: alloc_pct = 60;
				default: alloc_pct = 30;
			endcase
			if (fill_phase)
				phase_words = 90;
			else if (phase == 4 || phase == 13)
				phase_words = 70;
			else
				phase_words = $urandom_range(15, 60);
			for (int i = 0; i < phase_words; i++) begin
				if (fill_phase) begin
					queue_cmd(CMD_ALLOC, $urandom_range(25, 63), 0);
				end else if ($urandom_range(0, 99) < 5) begin
					// noise: any field values
					queue_cmd(($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE,
						$urandom_range(0, 127), $urandom_range(0, 8191));
				end else if (live_runs.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
					queue_cmd(CMD_ALLOC, pick_run_len(), $urandom_range(0, 8191));
				end else begin
					k      = $urandom_range(0, live_runs.size() - 1);
					victim = live_runs[k];
					live_runs.delete(k);
					queue_cmd(CMD_FREE, victim.len, victim.first);
				end
				random_words++;
			end
			// long receiver hold while the sender keeps offering
			if (phase == 4 || phase == 13)
				hold_asks++;
			wait_drained();
			phase++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
